// ===== rtl/sldt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the smoothing line detector.
// No dependencies; every other file of the block refers to it by scoped names.
package sldt_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int THRESHOLD_W = 12;
  localparam int WIDTH_REG_W = 9;
  localparam int HEIGHT_W    = 16;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST    = 12'd25;
  localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST  = 9'd200;
  localparam logic [HEIGHT_W-1:0]    IMAGE_HEIGHT_RST = 16'd200;

  // floor(sum / 9) == (sum * RECIP9) >> RECIP9_SHIFT for every 3x3 sum of 8-bit pixels
  localparam logic [12:0] RECIP9       = 13'd7282;
  localparam int          RECIP9_SHIFT = 16;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  // Decoupling queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;

  // 3x3 window: [row][column], row 0 oldest line, column 2 newest pixel
  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    win_t win;
    logic row_end;
    logic frame_end;
  } win_item_t;

endpackage

// ===== rtl/sldt_front.sv =====
`timescale 1ns / 1ps
// Front end: raster counters, raw line buffer, 3x3 mean, smoothed line buffer and window.
// Uses sldt_pkg; feeds complete smoothed windows into sldt_queue.
module sldt_front #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sldt_pkg::in_item_t                in_data,
  input  logic [sldt_pkg::WIDTH_REG_W-1:0]  image_width,
  input  logic [sldt_pkg::HEIGHT_W-1:0]     image_height,
  input  logic [sldt_pkg::Q_CW-1:0]         q_count,
  output logic                              push_valid,
  output sldt_pkg::win_item_t               push_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > sldt_pkg::WIDTH_REG_W) ? CW + 1 : sldt_pkg::WIDTH_REG_W;
  localparam int HW = sldt_pkg::HEIGHT_W;

  typedef struct packed {
    logic smooth;
    logic emit;
    logic row_end;
    logic frame_end;
  } tag_t;

  // line stores: {older row, newer row} per column
  logic [15:0] raw_mem [MAX_WIDTH];
  logic [15:0] sm_mem  [MAX_WIDTH];

  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;

  logic          s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic [CW-1:0] s1_c_r, s2_c_r, s3_c_r, s4_c_r;
  logic [7:0]    s1_p_r;
  tag_t          s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic [11:0]   s3_sum_r;
  logic [7:0]    s4_s_r;

  logic [15:0]   raw_rd_r, raw_fwd_data_r;
  logic          raw_fwd_r;
  logic [15:0]   sm_rd_r, sm_fwd_data_r;
  logic          sm_fwd_r;

  logic [2:0][9:0] cs_r;
  sldt_pkg::win_t  win_r;

  logic          accept;
  logic [CW-1:0] c_cur;
  logic [HW-1:0] r_cur;
  logic [WW-1:0] w_ext, w_clamp;
  logic [CW:0]   w_eff;
  logic [HW-1:0] h_eff;
  logic          last_col, last_row;
  tag_t          tag_cur;
  logic [15:0]   raw_pair, raw_wr_data;
  logic [15:0]   sm_pair, sm_wr_data;
  logic [11:0]   sum3;
  logic [24:0]   prod;
  logic [2:0]    inflight;
  logic [sldt_pkg::Q_CW:0] occupancy;

  // admit only while the queue can hold everything already in the pipe
  assign inflight  = 3'(s1_valid_r) + 3'(s2_valid_r) + 3'(s3_valid_r)
                   + 3'(s4_valid_r) + 3'(s5_valid_r);
  assign occupancy = (sldt_pkg::Q_CW+1)'(q_count) + (sldt_pkg::Q_CW+1)'(inflight);
  assign in_ready  = occupancy < (sldt_pkg::Q_CW+1)'(sldt_pkg::Q_DEPTH);
  assign accept    = in_valid && in_ready;

  // effective geometry
  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext > WW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else if (w_ext == '0) begin
      w_clamp = WW'(1);
    end else begin
      w_clamp = w_ext;
    end
    w_eff = w_clamp[CW:0];
    h_eff = (image_height == '0) ? HW'(1) : image_height;
  end

  // classify the incoming pixel by its raster position
  always_comb begin
    c_cur    = in_data.frame_start ? '0 : col_r;
    r_cur    = in_data.frame_start ? '0 : row_r;
    last_col = ({1'b0, c_cur} + (CW+1)'(1)) >= w_eff;
    last_row = ({1'b0, r_cur} + (HW+1)'(1)) >= {1'b0, h_eff};
    tag_cur.smooth    = (r_cur >= HW'(2)) && ({1'b0, c_cur} >= (CW+1)'(2));
    tag_cur.emit      = (r_cur >= HW'(4)) && ({1'b0, c_cur} >= (CW+1)'(4));
    tag_cur.row_end   = last_col;
    tag_cur.frame_end = last_col && last_row;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r_cur + HW'(1);
      end else begin
        col_nxt = c_cur + CW'(1);
        row_nxt = r_cur;
      end
    end
  end

  // raw column and its update, with bypass of the write issued on the read edge
  assign raw_pair    = raw_fwd_r ? raw_fwd_data_r : raw_rd_r;
  assign raw_wr_data = {raw_pair[7:0], s1_p_r};

  // mean of the nine raw pixels
  assign sum3 = 12'(cs_r[0]) + 12'(cs_r[1]) + 12'(cs_r[2]);
  assign prod = 25'(s3_sum_r) * 25'(sldt_pkg::RECIP9);

  // smoothed column and its update
  assign sm_pair    = sm_fwd_r ? sm_fwd_data_r : sm_rd_r;
  assign sm_wr_data = {sm_pair[7:0], s4_s_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      raw_fwd_r  <= 1'b0;
      sm_fwd_r   <= 1'b0;
      cs_r       <= '0;
      win_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && s2_tag_r.smooth;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r && s4_tag_r.emit;
      raw_fwd_r  <= s1_valid_r && (s1_c_r == c_cur);
      sm_fwd_r   <= s4_valid_r && (s4_c_r == s3_c_r);
      // shift the column sums of the raw window
      if (s1_valid_r) begin
        cs_r[0] <= cs_r[1];
        cs_r[1] <= cs_r[2];
        cs_r[2] <= 10'(raw_pair[15:8]) + 10'(raw_pair[7:0]) + 10'(s1_p_r);
      end
      // shift the smoothed window
      if (s4_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= sm_pair[15:8];
        win_r[1][2] <= sm_pair[7:0];
        win_r[2][2] <= s4_s_r;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    s1_c_r         <= c_cur;
    s1_p_r         <= in_data.pixel;
    s1_tag_r       <= tag_cur;
    s2_c_r         <= s1_c_r;
    s2_tag_r       <= s1_tag_r;
    s3_c_r         <= s2_c_r;
    s3_tag_r       <= s2_tag_r;
    s3_sum_r       <= sum3;
    s4_c_r         <= s3_c_r;
    s4_tag_r       <= s3_tag_r;
    s4_s_r         <= prod[sldt_pkg::RECIP9_SHIFT +: 8];
    s5_tag_r       <= s4_tag_r;
    raw_fwd_data_r <= raw_wr_data;
    sm_fwd_data_r  <= sm_wr_data;
  end

  // raw line store
  always_ff @(posedge clk) begin
    raw_rd_r <= raw_mem[c_cur];
    if (s1_valid_r) begin
      raw_mem[s1_c_r] <= raw_wr_data;
    end
  end

  // smoothed line store
  always_ff @(posedge clk) begin
    sm_rd_r <= sm_mem[s3_c_r];
    if (s4_valid_r) begin
      sm_mem[s4_c_r] <= sm_wr_data;
    end
  end

  // hand the finished window to the queue
  assign push_valid          = s5_valid_r;
  assign push_data.win       = win_r;
  assign push_data.row_end   = s5_tag_r.row_end;
  assign push_data.frame_end = s5_tag_r.frame_end;

  a_raw_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    raw_fwd_r |-> $past(s1_valid_r))
    else $error("raw bypass taken without a write in flight");

  a_emit_from_smooth: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> $past(s4_valid_r))
    else $error("window request without a smoothed item behind it");

endmodule

// ===== rtl/sldt_queue.sv =====
`timescale 1ns / 1ps
// Short queue of smoothed windows between the front and the back.
// Uses sldt_pkg; the front pushes without a ready, sized by its admission count.
module sldt_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  input  sldt_pkg::win_item_t        push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output sldt_pkg::win_item_t        pop_data,
  output logic [sldt_pkg::Q_CW-1:0]  count
);

  sldt_pkg::win_item_t              mem_r [sldt_pkg::Q_DEPTH];
  logic [sldt_pkg::Q_AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [sldt_pkg::Q_CW-1:0]        count_r;
  logic                             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + sldt_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sldt_pkg::Q_AW'(1);
      end
      count_r <= count_r + sldt_pkg::Q_CW'(push_valid) - sldt_pkg::Q_CW'(pop);
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (count_r != sldt_pkg::Q_CW'(sldt_pkg::Q_DEPTH)) || pop)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sldt_pkg::Q_CW'(sldt_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/sldt_back.sv =====
`timescale 1ns / 1ps
// Back end: four line masks over the smoothed window, threshold test, output register.
// Uses sldt_pkg; takes windows from sldt_queue.
module sldt_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  sldt_pkg::win_item_t                q_data,
  input  logic [sldt_pkg::THRESHOLD_W-1:0]   threshold,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sldt_pkg::out_item_t                out_data
);

  // mask response: 2 * line - rest = 3 * line - total
  function automatic logic signed [13:0] resp(input logic [9:0] line, input logic [11:0] total);
    logic [11:0] tri_line;
    tri_line = {1'b0, line, 1'b0} + 12'(line);
    return $signed({2'b00, tri_line}) - $signed({2'b00, total});
  endfunction

  logic        b1_valid_r;
  logic [11:0] total_r;
  logic [9:0]  lh_r, lv_r, lp_r, lm_r;
  logic        b1_row_end_r, b1_frame_end_r;
  logic        out_valid_r;
  sldt_pkg::out_item_t out_data_r;

  logic        out_take, b1_ready, b1_move;
  logic [9:0]  rs0, rs1, rs2;
  logic signed [13:0] thr;
  logic        hit;
  sldt_pkg::win_t w;

  assign out_take = !out_valid_r || out_ready;
  assign b1_ready = !b1_valid_r || out_take;
  assign q_ready  = b1_ready;
  assign b1_move  = b1_valid_r && out_take;
  assign w        = q_data.win;

  // row sums of the incoming window
  assign rs0 = 10'(w[0][0]) + 10'(w[0][1]) + 10'(w[0][2]);
  assign rs1 = 10'(w[1][0]) + 10'(w[1][1]) + 10'(w[1][2]);
  assign rs2 = 10'(w[2][0]) + 10'(w[2][1]) + 10'(w[2][2]);

  // threshold test on all four responses
  assign thr = $signed({{2{threshold[sldt_pkg::THRESHOLD_W-1]}}, threshold});
  assign hit = (resp(lh_r, total_r) >= thr) || (resp(lv_r, total_r) >= thr)
            || (resp(lp_r, total_r) >= thr) || (resp(lm_r, total_r) >= thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_r <= q_valid;
      end
      if (out_take) begin
        out_valid_r <= b1_valid_r;
      end
    end
  end

  // stage line sums, then the result
  always_ff @(posedge clk) begin
    if (q_valid && b1_ready) begin
      total_r        <= 12'(rs0) + 12'(rs1) + 12'(rs2);
      lh_r           <= rs1;
      lv_r           <= 10'(w[0][1]) + 10'(w[1][1]) + 10'(w[2][1]);
      lp_r           <= 10'(w[0][2]) + 10'(w[1][1]) + 10'(w[2][0]);
      lm_r           <= 10'(w[0][0]) + 10'(w[1][1]) + 10'(w[2][2]);
      b1_row_end_r   <= q_data.row_end;
      b1_frame_end_r <= q_data.frame_end;
    end
    if (b1_move) begin
      out_data_r.edge_value <= hit ? sldt_pkg::EDGE_ON : sldt_pkg::EDGE_OFF;
      out_data_r.row_end    <= b1_row_end_r;
      out_data_r.frame_end  <= b1_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_end |-> out_data_r.row_end)
    else $error("frame end without row end");

endmodule

// ===== rtl/smooth_line_detect_threshold_unit.sv =====
`timescale 1ns / 1ps
// Results pass stages s1 to s5, the queue, stage b1 and the output register; the first
// output pixel of a frame follows input pixel (4,4), the block emits nothing before it.
// Throughput: one pixel per clock while in_ready is high; one read and one write per
// line store each cycle. Reset (synchronous, rst_n low): counters, pipeline and queue
// empty, registers threshold 25, width 200, height 200; line stores are not cleared.
module smooth_line_detect_threshold_unit #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sldt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sldt_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [sldt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sldt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [sldt_pkg::THRESHOLD_W-1:0] threshold_r;
  logic [sldt_pkg::WIDTH_REG_W-1:0] image_width_r;
  logic [sldt_pkg::HEIGHT_W-1:0]    image_height_r;

  logic                       push_valid;
  sldt_pkg::win_item_t        push_data;
  logic                       q_valid, q_ready;
  sldt_pkg::win_item_t        q_data;
  logic [sldt_pkg::Q_CW-1:0]  q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= sldt_pkg::THRESHOLD_RST;
      image_width_r  <= sldt_pkg::IMAGE_WIDTH_RST;
      image_height_r <= sldt_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sldt_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[sldt_pkg::THRESHOLD_W-1:0];
        sldt_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[sldt_pkg::WIDTH_REG_W-1:0];
        sldt_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[sldt_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  sldt_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  sldt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .count      (q_count)
  );

  sldt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .threshold (threshold_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
